// ===== hdl/sfbe_pkg.sv =====
`timescale 1ns / 1ps
package sfbe_pkg;

  // store depth; a power of two, so index wrap and k mod POINTS are masks
  localparam int POINTS    = 256;

  // port field widths
  localparam int PERIODS_W = 7;
  localparam int IDX_W     = 8;
  localparam int SAMPLE_W  = 24;
  localparam int BIN_W     = 8;
  localparam int VALUE_W   = 48;

  // command field codes
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_BIN  = 1'b1;

  typedef struct packed {
    logic       store;        // write one sample into the stores
    logic       capture;      // latch k, k mod POINTS and the twiddle step
    logic       mac_clear;
    logic       mac_issue;
    logic       mag_take;     // magnitude and sign of the sum
    logic       scale_take;   // magnitude times periods/POINTS
    logic       result_fire;  // register the final value
  } cmd_t;

  typedef struct packed {
    logic issue_last;
    logic pipe_empty;
  } sts_t;

endpackage

// ===== hdl/sampled_fourier_bin_evaluator_core.sv =====
// channel   signals                                            transfer when
// --------  -------------------------------------------------  -------------------------
// input     start, busy, command_i, sample_index_i,            start && !busy
//           sample_real_i, sample_imag_i, bin_i
// result    bin_valid_o, bin_value_o, bin_echo_o               bin_valid_o (one cycle)
// config    cfg_valid_i, cfg_ready_o, cfg_periods_i            cfg_valid_i && cfg_ready_o
//
// A sample load never raises busy. A bin request keeps busy high while the
// stored samples pass through the MAC, one per cycle, while the
// read/multiply/accumulate pipe drains, while the magnitude is scaled by
// periods/POINTS and while the value is signed, saturated and registered.
// The result strobe comes in the first cycle with busy low again.
// Reset clears the controller and sets periods to 1; the sample RAMs are not
// cleared. The result strobe lasts one cycle and the receiver cannot stall it.
`timescale 1ns / 1ps
module sampled_fourier_bin_evaluator_core
  import sfbe_pkg::*;
#(
  parameter int TWIDDLE_BITS = 18
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start,
  output logic                        busy,
  input  logic                        command_i,
  input  logic [IDX_W-1:0]            sample_index_i,
  input  logic signed [SAMPLE_W-1:0]  sample_real_i,
  input  logic signed [SAMPLE_W-1:0]  sample_imag_i,
  input  logic signed [BIN_W-1:0]     bin_i,
  output logic                        bin_valid_o,
  output logic signed [VALUE_W-1:0]   bin_value_o,
  output logic signed [BIN_W-1:0]     bin_echo_o,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [PERIODS_W-1:0]        cfg_periods_i
);

  cmd_t cmd;
  sts_t sts;

  // periods is only to be rewritten while idle; the block leaves this to the user, so writes are always taken
  assign cfg_ready_o = 1'b1;

  sfbe_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start),
    .command_i (command_i),
    .sts_i     (sts),
    .cmd_o     (cmd),
    .busy_o    (busy),
    .valid_o   (bin_valid_o)
  );

  sfbe_datapath #(
    .TWIDDLE_BITS (TWIDDLE_BITS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .cfg_valid_i    (cfg_valid_i && cfg_ready_o),
    .cfg_periods_i  (cfg_periods_i),
    .sample_index_i (sample_index_i),
    .sample_real_i  (sample_real_i),
    .sample_imag_i  (sample_imag_i),
    .bin_i          (bin_i),
    .bin_value_o    (bin_value_o),
    .bin_echo_o     (bin_echo_o)
  );

endmodule

// ===== hdl/sfbe_ram.sv =====
`timescale 1ns / 1ps
module sfbe_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/sfbe_datapath.sv =====
`timescale 1ns / 1ps
module sfbe_datapath
  import sfbe_pkg::*;
#(
  parameter int TWIDDLE_BITS = 18
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cmd_t                        cmd_i,
  output sts_t                        sts_o,
  input  logic                        cfg_valid_i,
  input  logic [PERIODS_W-1:0]        cfg_periods_i,
  input  logic [IDX_W-1:0]            sample_index_i,
  input  logic signed [SAMPLE_W-1:0]  sample_real_i,
  input  logic signed [SAMPLE_W-1:0]  sample_imag_i,
  input  logic signed [BIN_W-1:0]     bin_i,
  output logic signed [VALUE_W-1:0]   bin_value_o,
  output logic signed [BIN_W-1:0]    bin_echo_o
);

  localparam int AW       = $clog2(POINTS);
  localparam int TW       = TWIDDLE_BITS;
  localparam int PR_W     = SAMPLE_W + TW;
  localparam int ACC_W    = PR_W + 1 + AW;
  localparam int BIN_SPAN = 1 << (BIN_W - 1);
  // smallest multiple of POINTS that makes every k non-negative
  localparam int OFFS     = POINTS * ((BIN_SPAN + POINTS - 1) / POINTS);
  localparam int KW       = $clog2(OFFS + BIN_SPAN);
  localparam int SW       = AW + PERIODS_W;
  localparam int DIV_W    = ACC_W + PERIODS_W + 1;
  localparam int SC_W     = DIV_W - AW;
  localparam int HALF_P   = POINTS / 2;
  localparam int EXT_W    = (DIV_W > VALUE_W) ? DIV_W : VALUE_W + 1;
  localparam int SH       = 32 - TW;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint ONE_Q30     = 64'sd1 <<< 30;

  // cos or sin of 2*pi*idx/POINTS: octant reduction, Taylor series in Q30,
  // rounded half away from zero to Q1.(TW-2)
  function automatic longint tw_value(input int idx, input bit want_sin);
    longint q, oct, r, quad, u, x, x2, tc, ts, ac, av, c, s, rc, rs, v, mag;
    q    = 8 * idx;
    oct  = q / POINTS;
    r    = q % POINTS;
    quad = oct / 2;
    u    = (oct % 2) * POINTS + r;
    if (u <= POINTS) begin
      x = (HALF_PI_Q30 * u) / (2 * POINTS);
    end else begin
      x = (HALF_PI_Q30 * (2 * POINTS - u)) / (2 * POINTS);
    end
    x2 = (x * x) >>> 30;
    tc = ONE_Q30;
    ac = ONE_Q30;
    ts = x;
    av = x;
    // six terms, divisors (2n-1)(2n) and (2n)(2n+1)
    tc = ((tc * x2) >>> 30) / 2;
    ts = ((ts * x2) >>> 30) / 6;
    ac = ac - tc;
    av = av - ts;
    tc = ((tc * x2) >>> 30) / 12;
    ts = ((ts * x2) >>> 30) / 20;
    ac = ac + tc;
    av = av + ts;
    tc = ((tc * x2) >>> 30) / 30;
    ts = ((ts * x2) >>> 30) / 42;
    ac = ac - tc;
    av = av - ts;
    tc = ((tc * x2) >>> 30) / 56;
    ts = ((ts * x2) >>> 30) / 72;
    ac = ac + tc;
    av = av + ts;
    tc = ((tc * x2) >>> 30) / 90;
    ts = ((ts * x2) >>> 30) / 110;
    ac = ac - tc;
    av = av - ts;
    tc = ((tc * x2) >>> 30) / 132;
    ts = ((ts * x2) >>> 30) / 156;
    ac = ac + tc;
    av = av + ts;
    if (u <= POINTS) begin
      c = ac;
      s = av;
    end else begin
      c = av;
      s = ac;
    end
    case (quad % 4)
      0: begin
        rc = c;
        rs = s;
      end
      1: begin
        rc = -s;
        rs = c;
      end
      2: begin
        rc = -c;
        rs = -s;
      end
      default: begin
        rc = s;
        rs = -c;
      end
    endcase
    v   = want_sin ? rs : rc;
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'sd1 <<< (SH - 1))) >>> SH;
    return (v < 0) ? -mag : mag;
  endfunction

  logic signed [TW-1:0] cos_tab [POINTS];
  logic signed [TW-1:0] sin_tab [POINTS];

  for (genvar g = 0; g < POINTS; g++) begin : g_rom
    localparam logic signed [TW-1:0] CosV = TW'(tw_value(g, 1'b0));
    localparam logic signed [TW-1:0] SinV = TW'(tw_value(g, 1'b1));
    assign cos_tab[g] = CosV;
    assign sin_tab[g] = SinV;
  end

  // configuration
  logic [PERIODS_W-1:0] periods_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      periods_q <= PERIODS_W'(1);
    end else if (cfg_valid_i) begin
      periods_q <= cfg_periods_i;
    end
  end

  // sample stores
  logic                store_we;
  logic [AW-1:0]       waddr;
  logic [AW-1:0]       i_q;
  logic [SAMPLE_W-1:0] re_rd;
  logic [SAMPLE_W-1:0] im_rd;

  assign store_we = cmd_i.store && (32'(sample_index_i) < 32'(POINTS));
  assign waddr    = AW'(sample_index_i);

  sfbe_ram #(.WIDTH(SAMPLE_W), .DEPTH(POINTS)) u_real_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (waddr),
    .wdata_i (sample_real_i),
    .raddr_i (i_q),
    .rdata_o (re_rd)
  );

  sfbe_ram #(.WIDTH(SAMPLE_W), .DEPTH(POINTS)) u_imag_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (waddr),
    .wdata_i (sample_imag_i),
    .raddr_i (i_q),
    .rdata_o (im_rd)
  );

  // bin request registers; both remainders by POINTS are low-bit masks
  logic [KW-1:0]            k_ofs;
  logic [AW-1:0]            kk_d;
  logic [SW-1:0]            step_prod;
  logic [AW-1:0]            kk_q;
  logic [AW-1:0]            step_q;
  logic signed [BIN_W-1:0]  bin_q;

  assign k_ofs     = KW'(bin_i) + KW'(OFFS);
  assign kk_d      = AW'(k_ofs);
  assign step_prod = SW'(periods_q) * SW'(kk_d);

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      bin_q  <= bin_i;
      kk_q   <= kk_d;
      step_q <= AW'(step_prod);
    end
  end

  // multiply-accumulate: read, multiply, accumulate
  logic [AW-1:0]             m_q;
  logic [AW:0]               m_sum;
  logic signed [TW-1:0]      tc_q;
  logic signed [TW-1:0]      ts_q;
  logic signed [PR_W-1:0]    pr_q;
  logic signed [PR_W-1:0]    pi_q;
  logic signed [ACC_W-1:0]   acc_q;
  logic                      v1_q;
  logic                      v2_q;
  logic                      sum_neg_q;
  logic [ACC_W-1:0]          umag_q;

  assign m_sum = {1'b0, m_q} + {1'b0, step_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= cmd_i.mac_issue;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mac_clear) begin
      i_q <= '0;
      m_q <= '0;
    end else if (cmd_i.mac_issue) begin
      i_q <= i_q + AW'(1);
      m_q <= (m_sum >= (AW+1)'(POINTS)) ? AW'(m_sum - (AW+1)'(POINTS)) : AW'(m_sum);
    end
    if (cmd_i.mac_issue) begin
      tc_q <= cos_tab[m_q];
      ts_q <= sin_tab[m_q];
    end
    if (v1_q) begin
      pr_q <= PR_W'($signed(re_rd)) * PR_W'(tc_q);
      pi_q <= PR_W'($signed(im_rd)) * PR_W'(ts_q);
    end
    if (cmd_i.mac_clear) begin
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + ACC_W'(pr_q) - ACC_W'(pi_q);
    end
    if (cmd_i.mag_take) begin
      sum_neg_q <= acc_q[ACC_W-1];
      umag_q    <= acc_q[ACC_W-1] ? ACC_W'(-acc_q) : ACC_W'(acc_q);
    end
  end

  // scaling by periods/POINTS
  logic [DIV_W-1:0]          scale_num;
  logic [SC_W-1:0]           scaled_q;

  // round half up: (|sum| * periods + POINTS/2) / POINTS
  assign scale_num = DIV_W'(umag_q) * DIV_W'(periods_q) + DIV_W'(HALF_P);

  always_ff @(posedge clk_i) begin
    if (cmd_i.scale_take) begin
      scaled_q <= scale_num[DIV_W-1:AW];
    end
  end

  // sign rule and saturation
  logic [EXT_W-1:0]          mag_ext;
  logic [EXT_W-1:0]          lim;
  logic                      neg;
  logic signed [VALUE_W-1:0] value_d;
  logic signed [VALUE_W-1:0] value_q;
  logic signed [BIN_W-1:0]   echo_q;

  assign mag_ext = EXT_W'(scaled_q);
  assign lim     = EXT_W'({1'b1, {(VALUE_W-1){1'b0}}});
  assign neg     = sum_neg_q ^ (periods_q[0] & kk_q[0]);

  always_comb begin
    if (!neg) begin
      value_d = (mag_ext >= lim) ? {1'b0, {(VALUE_W-1){1'b1}}} : VALUE_W'(mag_ext);
    end else begin
      value_d = (mag_ext > lim) ? {1'b1, {(VALUE_W-1){1'b0}}} : VALUE_W'(-mag_ext);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_fire) begin
      value_q <= value_d;
      echo_q  <= bin_q;
    end
  end

  assign bin_value_o = value_q;
  assign bin_echo_o  = echo_q;

  assign sts_o.issue_last = (i_q == AW'(POINTS - 1));
  assign sts_o.pipe_empty = !v1_q && !v2_q;

  a_pipe_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v2_q |-> $past(v1_q))
    else $error("accumulate stage without a multiply before it");

  a_fire_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.result_fire |-> !v1_q && !v2_q)
    else $error("result taken while MAC still busy");

  a_clear_quiet : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mac_clear |-> !v1_q && !v2_q)
    else $error("MAC cleared with products still in flight");

endmodule

// ===== hdl/sfbe_ctrl.sv =====
`timescale 1ns / 1ps
module sfbe_ctrl
  import sfbe_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  input  logic command_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic busy_o,
  output logic valid_o
);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_MAC      = 3'd1;
  localparam logic [2:0] ST_DRAIN    = 3'd2;
  localparam logic [2:0] ST_NORM     = 3'd3;
  localparam logic [2:0] ST_SCALE    = 3'd4;

  logic [2:0] state_q;
  logic [2:0] state_d;
  logic       valid_q;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i && command_i == CMD_LOAD) begin
          cmd_o.store = 1'b1;
        end
        if (start_i && command_i == CMD_BIN) begin
          cmd_o.capture   = 1'b1;
          cmd_o.mac_clear = 1'b1;
          state_d         = ST_MAC;
        end
      end
      ST_MAC: begin
        cmd_o.mac_issue = 1'b1;
        if (sts_i.issue_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (sts_i.pipe_empty) begin
          cmd_o.mag_take = 1'b1;
          state_d        = ST_NORM;
        end
      end
      ST_NORM: begin
        cmd_o.scale_take = 1'b1;
        state_d          = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.result_fire = 1'b1;
        state_d           = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= cmd_o.result_fire;
    end
  end

  assign busy_o  = (state_q != ST_IDLE);
  assign valid_o = valid_q;

  a_valid_src : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> $past(state_q) == ST_SCALE)
    else $error("result strobe not preceded by the scaling pass");

  a_mac_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAC && !sts_i.issue_last) |=> state_q == ST_MAC)
    else $error("MAC pass left before the last sample");

  a_req_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && command_i == CMD_BIN) |=> busy_o)
    else $error("bin request accepted without going busy");

endmodule

// ===== verif/sfbe_bin_checker.sv =====
`timescale 1ns / 1ps
module sfbe_bin_checker
  import sfbe_pkg::*;
#(
  parameter int TWIDDLE_BITS = 18
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  logic                       command_i,
  input  logic [IDX_W-1:0]           sample_index_i,
  input  logic signed [SAMPLE_W-1:0] sample_real_i,
  input  logic signed [SAMPLE_W-1:0] sample_imag_i,
  input  logic signed [BIN_W-1:0]    bin_i,
  input  logic                       bin_valid_i,
  input  logic signed [VALUE_W-1:0]  bin_value_i,
  input  logic signed [BIN_W-1:0]    bin_echo_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [PERIODS_W-1:0]       cfg_periods_i,
  output int                         pending_o,
  output int                         errors_o
);

  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint SAT_MAX     = (64'sd1 <<< 47) - 64'sd1;
  localparam longint SAT_MIN     = -(64'sd1 <<< 47);
  localparam int     TW_SHIFT    = 30 - (TWIDDLE_BITS - 2);

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic signed [BIN_W-1:0]   echo;
  } bin_result_t;

  bin_result_t bin_expect_q[$];

  int cos_tw[POINTS];
  int sin_tw[POINTS];
  logic signed [SAMPLE_W-1:0] re_mem[POINTS];
  logic signed [SAMPLE_W-1:0] im_mem[POINTS];
  logic [PERIODS_W-1:0] periods_q;
  int fail_count = 0;

  assign errors_o = fail_count;

  task automatic report_mismatch(input string msg);
    $display("[%0t] bin checker: %s", $time, msg);
    fail_count++;
  endtask

  // cos/sin in Q30 of x in [0, pi/4], six Taylor terms
  task automatic taylor_cs(input longint x, output longint c, output longint s);
    longint x2, tc, ts, cos_acc, sin_acc;
    int n;
    x2 = (x * x) >>> 30;
    tc = 64'sd1 <<< 30;
    cos_acc = tc;
    ts = x;
    sin_acc = x;
    for (n = 1; n <= 6; n++) begin
      tc = ((tc * x2) >>> 30) / longint'((2 * n - 1) * (2 * n));
      ts = ((ts * x2) >>> 30) / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        cos_acc -= tc;
        sin_acc -= ts;
      end else begin
        cos_acc += tc;
        sin_acc += ts;
      end
    end
    c = cos_acc;
    s = sin_acc;
  endtask

  function automatic int round_twiddle(input longint v);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'sd1 <<< (TW_SHIFT - 1))) >>> TW_SHIFT;
    return (v < 0) ? -int'(mag) : int'(mag);
  endfunction

  initial begin : build_twiddles
    longint p, q, oct, r, quad, u, c, s, rc, rs;
    int idx;
    p = POINTS;
    for (idx = 0; idx < POINTS; idx++) begin
      q = 8 * idx;
      oct = q / p;
      r = q % p;
      quad = oct / 2;
      u = (oct % 2) * p + r;
      // upper half of an octant pair is folded onto pi/2 - x
      if (u <= p) taylor_cs((HALF_PI_Q30 * u) / (2 * p), c, s);
      else taylor_cs((HALF_PI_Q30 * (2 * p - u)) / (2 * p), s, c);
      case (quad % 4)
        0: begin rc = c;  rs = s;  end
        1: begin rc = -s; rs = c;  end
        2: begin rc = -c; rs = -s; end
        default: begin rc = s; rs = -c; end
      endcase
      cos_tw[idx] = round_twiddle(rc);
      sin_tw[idx] = round_twiddle(rs);
    end
  end

  function automatic logic signed [VALUE_W-1:0] fourier_bin_value(
      input logic signed [BIN_W-1:0] k, input logic [PERIODS_W-1:0] per);
    longint p, pl, kv, kk, step, m, sum, umag, q, rem, mag, res;
    bit neg;
    int i;
    p = POINTS;
    pl = per;
    kv = k;
    kk = ((kv % p) + p) % p;
    step = (pl * kk) % p;
    m = 0;
    sum = 0;
    for (i = 0; i < POINTS; i++) begin
      sum += longint'(re_mem[i]) * longint'(cos_tw[m])
           - longint'(im_mem[i]) * longint'(sin_tw[m]);
      m += step;
      if (m >= p) m -= p;
    end
    neg = (sum < 0);
    umag = neg ? -sum : sum;
    q = umag / p;
    rem = umag % p;
    // scale by periods/POINTS, round half away from zero
    mag = q * pl + (rem * pl + p / 2) / p;
    if (pl[0] && kk[0]) neg = !neg;
    res = neg ? -mag : mag;
    if (res > SAT_MAX) res = SAT_MAX;
    if (res < SAT_MIN) res = SAT_MIN;
    return res[VALUE_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    bin_result_t exp_r;
    if (!rst_ni) begin
      periods_q = 7'd1;
      bin_expect_q.delete();
      pending_o <= 0;
    end else begin
      if (bin_valid_i) begin
        if (bin_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result value=%0d echo=%0d",
                                    bin_value_i, bin_echo_i));
        end else begin
          exp_r = bin_expect_q.pop_front();
          if (bin_value_i !== exp_r.value)
            report_mismatch($sformatf("bin %0d: value %0d, expected %0d",
                                      exp_r.echo, bin_value_i, exp_r.value));
          if (bin_echo_i !== exp_r.echo)
            report_mismatch($sformatf("echo %0d, expected %0d", bin_echo_i, exp_r.echo));
        end
      end
      if (cfg_valid_i && cfg_ready_i) periods_q = cfg_periods_i;
      if (start_i && !busy_i) begin
        if (command_i == CMD_LOAD) begin
          re_mem[sample_index_i] = sample_real_i;
          im_mem[sample_index_i] = sample_imag_i;
        end else begin
          exp_r.value = fourier_bin_value(bin_i, periods_q);
          exp_r.echo  = bin_i;
          bin_expect_q.push_back(exp_r);
        end
      end
      pending_o <= bin_expect_q.size();
    end
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import sfbe_pkg::*;

  localparam int CYCLE_LIMIT = 1_500_000;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = 24'sh800000;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       start;
  logic                       busy;
  logic                       command_i;
  logic [IDX_W-1:0]           sample_index_i;
  logic signed [SAMPLE_W-1:0] sample_real_i;
  logic signed [SAMPLE_W-1:0] sample_imag_i;
  logic signed [BIN_W-1:0]    bin_i;
  logic                       bin_valid_o;
  logic signed [VALUE_W-1:0]  bin_value_o;
  logic signed [BIN_W-1:0]    bin_echo_o;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [PERIODS_W-1:0]       cfg_periods_i;
  int                         pending;
  int                         errors;
  int unsigned                cycle_count = 0;

  sampled_fourier_bin_evaluator_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .command_i      (command_i),
    .sample_index_i (sample_index_i),
    .sample_real_i  (sample_real_i),
    .sample_imag_i  (sample_imag_i),
    .bin_i          (bin_i),
    .bin_valid_o    (bin_valid_o),
    .bin_value_o    (bin_value_o),
    .bin_echo_o     (bin_echo_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_periods_i  (cfg_periods_i)
  );

  sfbe_bin_checker bin_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .busy_i         (busy),
    .command_i      (command_i),
    .sample_index_i (sample_index_i),
    .sample_real_i  (sample_real_i),
    .sample_imag_i  (sample_imag_i),
    .bin_i          (bin_i),
    .bin_valid_i    (bin_valid_o),
    .bin_value_i    (bin_value_o),
    .bin_echo_i     (bin_echo_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_periods_i  (cfg_periods_i),
    .pending_o      (pending),
    .errors_o       (errors)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // start stays high across back-to-back transfers; a gap lowers it first
  task automatic push_item(input logic cmd, input logic [IDX_W-1:0] idx,
                           input logic signed [SAMPLE_W-1:0] re,
                           input logic signed [SAMPLE_W-1:0] im,
                           input logic signed [BIN_W-1:0] k, input bit allow_idle);
    int gap;
    gap = 0;
    if (allow_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 11);
    @(negedge clk_i);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start          = 1'b1;
    command_i      = cmd;
    sample_index_i = idx;
    sample_real_i  = re;
    sample_imag_i  = im;
    bin_i          = k;
    do @(posedge clk_i); while (busy);
  endtask

  task automatic ask_bin(input logic signed [BIN_W-1:0] k);
    push_item(CMD_BIN, IDX_W'($urandom), SAMPLE_W'($urandom), SAMPLE_W'($urandom), k,
              1'b1);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start = 1'b0;
    do @(posedge clk_i); while (pending != 0 || busy);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_periods(input logic [PERIODS_W-1:0] v);
    @(negedge clk_i);
    cfg_periods_i = v;
    cfg_valid_i   = 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic random_item(input bit allow_idle);
    logic                       cmd;
    logic [IDX_W-1:0]           idx;
    logic signed [SAMPLE_W-1:0] re;
    logic signed [SAMPLE_W-1:0] im;
    logic signed [BIN_W-1:0]    k;
    cmd = ($urandom_range(0, 99) < 35) ? CMD_BIN : CMD_LOAD;
    idx = IDX_W'($urandom);
    re  = SAMPLE_W'($urandom);
    im  = SAMPLE_W'($urandom);
    k   = BIN_W'($urandom);
    case ($urandom_range(0, 9))
      0: re = S_MAX;
      1: re = S_MIN;
      2: im = S_MAX;
      3: im = S_MIN;
      default: ;
    endcase
    push_item(cmd, idx, re, im, k, allow_idle);
  endtask

  function automatic logic [PERIODS_W-1:0] random_periods();
    case ($urandom_range(0, 7))
      0: return 7'd0;
      1: return 7'd127;
      2: return 7'd64;
      3: return 7'd1;
      4, 5: return PERIODS_W'($urandom_range(1, 64));
      default: return PERIODS_W'($urandom_range(0, 127));
    endcase
  endfunction

  initial begin : stimulus
    int n;
    int chunk;
    rst_ni         = 1'b0;
    start          = 1'b0;
    command_i      = CMD_LOAD;
    sample_index_i = '0;
    sample_real_i  = '0;
    sample_imag_i  = '0;
    bin_i          = '0;
    cfg_valid_i    = 1'b0;
    cfg_periods_i  = '0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    write_periods(7'd127);
    // every entry is written before the first request reads the store
    for (n = 0; n < 256; n++) push_item(CMD_LOAD, n[IDX_W-1:0], S_MAX, S_MIN, '0, 1'b1);
    ask_bin(8'sd0);
    ask_bin(8'sd32);
    ask_bin(-8'sd1);
    ask_bin(8'sd127);
    ask_bin(8'sh80);
    push_item(CMD_LOAD, 8'd0, S_MIN, S_MAX, '0, 1'b1);
    push_item(CMD_LOAD, 8'd255, '0, '0, '0, 1'b1);
    push_item(CMD_LOAD, 8'd128, 24'sd1, -24'sd1, '0, 1'b1);
    ask_bin(8'sd1);
    ask_bin(8'sd64);
    wait_drained();
    write_periods(7'd0);
    ask_bin(8'sd5);
    wait_drained();
    // odd periods with odd k flips the sign
    write_periods(7'd1);
    ask_bin(8'sd3);
    ask_bin(-8'sd3);
    wait_drained();
    write_periods(7'd64);
    ask_bin(8'sd3);
    ask_bin(8'sd2);
    wait_drained();
    write_periods(7'd3);
    ask_bin(-8'sd1);
    wait_drained();

    for (chunk = 0; chunk < 7; chunk++) begin
      write_periods(random_periods());
      repeat (61) random_item(chunk < 6);
      wait_drained();
    end

    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/sfbe_pkg.sv
hdl/sfbe_ram.sv
hdl/sfbe_datapath.sv
hdl/sfbe_ctrl.sv
hdl/sampled_fourier_bin_evaluator_core.sv
verif/sfbe_bin_checker.sv
verif/testbench.sv
